[rtl/core/vmx_pkg.sv]
`default_nettype none
package vmx_pkg;

  typedef enum logic [3:0] {
    OP_MOV  = 4'd0,
    OP_ADD  = 4'd1,
    OP_SUB  = 4'd2,
    OP_MUL  = 4'd3,
    OP_DIV  = 4'd4,
    OP_CMP  = 4'd5,
    OP_JMP  = 4'd6,
    OP_CALL = 4'd7,
    OP_RET  = 4'd8,
    OP_LD   = 4'd9,
    OP_ST   = 4'd10,
    OP_PUSH = 4'd11,
    OP_POP  = 4'd12,
    OP_HALT = 4'd13
  } op_e;

  typedef enum logic [2:0] {
    KIND_REG      = 3'd0,
    KIND_IMM      = 3'd1,
    KIND_REG_IND  = 3'd2,
    KIND_IMM_IND  = 3'd3,
    KIND_REG_DISP = 3'd4,
    KIND_IMM_DISP = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    JC_ALWAYS = 3'd0,
    JC_EQ     = 3'd1,
    JC_GT     = 3'd2,
    JC_GE     = 3'd3,
    JC_LT     = 3'd4,
    JC_LE     = 3'd5,
    JC_NE     = 3'd6
  } jcond_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ADDR  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_DIV_ZERO  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SZ_BYTE  = 2'd0,
    SZ_HALF  = 2'd1,
    SZ_WORD  = 2'd2,
    SZ_DWORD = 2'd3
  } size_e;

  localparam logic [1:0] FLAG_EQ = 2'b00;
  localparam logic [1:0] FLAG_GT = 2'b01;
  localparam logic [1:0] FLAG_LT = 2'b11;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_RD_S,
    CMD_RD_D,
    CMD_RD_SP,
    CMD_CAP,
    CMD_DECIDE,
    CMD_MUL,
    CMD_DIV,
    CMD_MEM,
    CMD_WR_SP,
    CMD_COMMIT
  } cmd_e;

  typedef enum logic [1:0] {
    CLS_DONE,
    CLS_MUL,
    CLS_DIV,
    CLS_MEM
  } cls_e;

  typedef enum logic [1:0] {
    SRC_ACC,
    SRC_QUO,
    SRC_MEM
  } src_e;

  typedef struct packed {
    cls_e cls;
    logic iter_done;
    logic mem_done;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

[rtl/core/vmx_ctrl.sv]
`default_nettype none
module vmx_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire vmx_pkg::stat_t stat,
  output vmx_pkg::cmd_e      cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_S,
    S_RD_D,
    S_RD_SP,
    S_CAP,
    S_DECIDE,
    S_MUL,
    S_DIV,
    S_MEM,
    S_WR_SP,
    S_COMMIT
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = vmx_pkg::CMD_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd = vmx_pkg::CMD_LOAD;
          state_next = S_RD_S;
        end
      end
      S_RD_S: begin
        cmd = vmx_pkg::CMD_RD_S;
        state_next = S_RD_D;
      end
      S_RD_D: begin
        cmd = vmx_pkg::CMD_RD_D;
        state_next = S_RD_SP;
      end
      S_RD_SP: begin
        cmd = vmx_pkg::CMD_RD_SP;
        state_next = S_CAP;
      end
      S_CAP: begin
        cmd = vmx_pkg::CMD_CAP;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd = vmx_pkg::CMD_DECIDE;
        case (stat.cls)
          vmx_pkg::CLS_MUL: state_next = S_MUL;
          vmx_pkg::CLS_DIV: state_next = S_DIV;
          vmx_pkg::CLS_MEM: state_next = S_MEM;
          default:          state_next = S_WR_SP;
        endcase
      end
      S_MUL: begin
        cmd = vmx_pkg::CMD_MUL;
        if (stat.iter_done) state_next = S_WR_SP;
      end
      S_DIV: begin
        cmd = vmx_pkg::CMD_DIV;
        if (stat.iter_done) state_next = S_WR_SP;
      end
      S_MEM: begin
        cmd = vmx_pkg::CMD_MEM;
        if (stat.mem_done) state_next = S_WR_SP;
      end
      S_WR_SP: begin
        cmd = vmx_pkg::CMD_WR_SP;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        // hold until the output register can take the result
        if (stat.out_free) begin
          cmd = vmx_pkg::CMD_COMMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

[rtl/core/vmx_dpath.sv]
`default_nettype none
module vmx_dpath #(
  parameter int NUM_REGS  = 16,
  parameter int STACK_REG = 15,
  parameter int MEM_BYTES = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [3:0]         mode,
  input  wire logic [3:0]         dst_reg,
  input  wire logic [3:0]         src_reg,
  input  wire logic [2:0]         operand_kind,
  input  wire logic [63:0]        imm,
  input  wire logic signed [15:0] disp,
  input  wire logic [1:0]         data_size,
  input  wire logic               sign_extend,
  input  wire logic [2:0]         jump_cond,
  input  wire vmx_pkg::cmd_e      cmd,
  input  wire logic               out_stall,
  output vmx_pkg::stat_t          stat,
  output logic                    out_valid,
  output logic [1:0]              status,
  output logic                    reg_written,
  output logic [63:0]             written_value,
  output logic                    jump_taken,
  output logic [63:0]             next_ip,
  output logic signed [1:0]       compare_flag,
  output logic                    is_running
);

  localparam int RI = $clog2(NUM_REGS);
  localparam int AW = $clog2(MEM_BYTES);
  localparam logic [RI-1:0] SP_IDX = RI'(STACK_REG % NUM_REGS);
  localparam logic [63:0] MEM_SIZE = 64'(MEM_BYTES);

  function automatic logic [RI-1:0] reg_index(input logic [3:0] v);
    logic [6:0] t;
    t = {3'b000, v};
    for (int i = 0; i < 8; i++) begin
      if (t >= 7'(NUM_REGS)) t = t - 7'(NUM_REGS);
    end
    return t[RI-1:0];
  endfunction

  function automatic logic [63:0] sext(input logic [63:0] v, input logic [1:0] sz);
    logic [63:0] r;
    case (sz)
      vmx_pkg::SZ_BYTE: r = {{56{v[7]}}, v[7:0]};
      vmx_pkg::SZ_HALF: r = {{48{v[15]}}, v[15:0]};
      vmx_pkg::SZ_WORD: r = {{32{v[31]}}, v[31:0]};
      default:          r = v;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] sign_flag(input logic [63:0] v);
    logic [1:0] f;
    if (v == 64'd0) f = vmx_pkg::FLAG_EQ;
    else if (v[63]) f = vmx_pkg::FLAG_LT;
    else f = vmx_pkg::FLAG_GT;
    return f;
  endfunction

  function automatic logic addr_ok(input logic [63:0] a, input logic [63:0] n);
    return a <= (MEM_SIZE - n);
  endfunction

  // latched instruction
  logic [3:0]    mode_q;
  logic [RI-1:0] d_q, s_q;
  logic [2:0]    kind_q;
  logic [63:0]   imm_q;
  logic [15:0]   disp_q;
  logic [1:0]    dsz_q;
  logic          sx_q;
  logic [2:0]    jc_q;

  // architectural state
  logic [63:0] ip;
  logic [1:0]  flag;
  logic        run;

  // register file with registered read and valid bits
  logic [63:0]         rf [NUM_REGS];
  logic [NUM_REGS-1:0] rf_vld;
  logic [63:0]         rf_q;
  logic                rf_q_vld;
  logic [RI-1:0]       rf_raddr, rf_waddr;
  logic                rf_we;
  logic [63:0]         rf_wdata, rf_rd;

  logic [63:0] aval, bval, spv;

  // decide stage
  logic [63:0] opv, tgt, dispx, ea, nb64, sum, diff, sp_m8, sp_mnb;
  logic [3:0]  nb4;
  logic        take;
  logic [1:0]  d_status;
  vmx_pkg::cls_e d_cls;
  vmx_pkg::src_e d_src;
  logic        d_wr, d_jt, d_run, d_sp_wr, d_ip_mem, d_mwr;
  logic [63:0] d_wval, d_ip, d_sp_new, d_mbase, d_wdata;
  logic [1:0]  d_flag;
  logic [2:0]  d_mlast;

  // held results
  logic [1:0]  res_status;
  vmx_pkg::src_e res_src;
  logic        res_wr, res_jt, res_run, res_sp_wr, res_ip_mem, res_mwr;
  logic [63:0] res_ip, res_sp_new, res_wdata;
  logic [1:0]  res_flag;
  logic [AW-1:0] res_mbase;
  logic [2:0]  res_mlast;

  // iterative multiply and divide
  logic [63:0] acc, ma, mb, rem;
  logic [5:0]  cnt;
  logic [64:0] dtmp;
  logic        dge;

  // byte memory
  logic [7:0]    mem [MEM_BYTES];
  logic [7:0]    mem_q;
  logic [AW-1:0] mem_addr;
  logic [2:0]    mcnt, rp_idx;
  logic          rp_vld;
  logic [63:0]   rdata;

  logic [63:0] wval_fin, ip_fin;

  always_ff @(posedge clk) begin
    if (cmd == vmx_pkg::CMD_LOAD) begin
      mode_q <= mode;
      d_q    <= reg_index(dst_reg);
      s_q    <= reg_index(src_reg);
      kind_q <= operand_kind;
      imm_q  <= imm;
      disp_q <= disp;
      dsz_q  <= data_size;
      sx_q   <= sign_extend;
      jc_q   <= jump_cond;
    end
  end

  always_comb begin
    case (cmd)
      vmx_pkg::CMD_RD_S: rf_raddr = s_q;
      vmx_pkg::CMD_RD_D: rf_raddr = d_q;
      default:           rf_raddr = SP_IDX;
    endcase
  end

  always_comb begin
    rf_we = 1'b0;
    rf_waddr = d_q;
    rf_wdata = wval_fin;
    if (cmd == vmx_pkg::CMD_WR_SP) begin
      rf_we = res_sp_wr;
      rf_waddr = SP_IDX;
      rf_wdata = res_sp_new;
    end else if (cmd == vmx_pkg::CMD_COMMIT) begin
      rf_we = res_wr;
    end
  end

  always_ff @(posedge clk) begin
    rf_q <= rf[rf_raddr];
    if (rf_we) rf[rf_waddr] <= rf_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld   <= '0;
      rf_q_vld <= 1'b0;
    end else begin
      rf_q_vld <= rf_vld[rf_raddr];
      if (rf_we) rf_vld[rf_waddr] <= 1'b1;
    end
  end

  assign rf_rd = rf_q_vld ? rf_q : 64'd0;

  always_ff @(posedge clk) begin
    case (cmd)
      vmx_pkg::CMD_RD_D:  bval <= rf_rd;
      vmx_pkg::CMD_RD_SP: aval <= rf_rd;
      vmx_pkg::CMD_CAP:   spv  <= rf_rd;
      default: ;
    endcase
  end

  always_comb begin
    opv   = (kind_q == vmx_pkg::KIND_IMM) ? imm_q : bval;
    tgt   = (kind_q == vmx_pkg::KIND_REG) ? bval : imm_q;
    dispx = {{48{disp_q[15]}}, disp_q};
    case (kind_q)
      vmx_pkg::KIND_REG_IND:  ea = bval;
      vmx_pkg::KIND_IMM_IND:  ea = imm_q;
      vmx_pkg::KIND_REG_DISP: ea = bval + dispx;
      vmx_pkg::KIND_IMM_DISP: ea = imm_q + dispx;
      default:                ea = 64'd0;
    endcase
    nb4    = 4'd1 << dsz_q;
    nb64   = 64'(nb4);
    sum    = aval + opv;
    diff   = aval - opv;
    sp_m8  = spv - 64'd8;
    sp_mnb = spv - nb64;
    case (jc_q)
      vmx_pkg::JC_ALWAYS: take = 1'b1;
      vmx_pkg::JC_EQ:     take = (flag == vmx_pkg::FLAG_EQ);
      vmx_pkg::JC_GT:     take = (flag == vmx_pkg::FLAG_GT);
      vmx_pkg::JC_GE:     take = (flag != vmx_pkg::FLAG_LT);
      vmx_pkg::JC_LT:     take = (flag == vmx_pkg::FLAG_LT);
      vmx_pkg::JC_LE:     take = (flag != vmx_pkg::FLAG_GT);
      vmx_pkg::JC_NE:     take = (flag != vmx_pkg::FLAG_EQ);
      default:            take = 1'b0;
    endcase
  end

  always_comb begin
    d_status = vmx_pkg::ST_OK;
    d_cls    = vmx_pkg::CLS_DONE;
    d_src    = vmx_pkg::SRC_ACC;
    d_wr     = 1'b0;
    d_wval   = 64'd0;
    d_jt     = 1'b0;
    d_ip     = ip;
    d_flag   = flag;
    d_run    = run;
    d_sp_wr  = 1'b0;
    d_sp_new = spv;
    d_ip_mem = 1'b0;
    d_mbase  = 64'd0;
    d_mlast  = 3'(nb4 - 4'd1);
    d_mwr    = 1'b0;
    d_wdata  = opv;
    case (mode_q)
      vmx_pkg::OP_MOV: begin
        d_wval = sx_q ? sext(opv, dsz_q) : opv;
        d_wr = 1'b1;
      end
      vmx_pkg::OP_ADD: begin
        d_wval = sum;
        d_wr = 1'b1;
      end
      vmx_pkg::OP_SUB: begin
        d_wval = diff;
        d_wr = 1'b1;
        d_flag = sign_flag(diff);
      end
      vmx_pkg::OP_MUL: begin
        d_cls = vmx_pkg::CLS_MUL;
        d_wr = 1'b1;
      end
      vmx_pkg::OP_DIV: begin
        if (opv == 64'd0) begin
          d_status = vmx_pkg::ST_DIV_ZERO;
        end else begin
          d_cls = vmx_pkg::CLS_DIV;
          d_src = vmx_pkg::SRC_QUO;
          d_wr = 1'b1;
        end
      end
      vmx_pkg::OP_CMP: d_flag = sign_flag(diff);
      vmx_pkg::OP_JMP: begin
        if (take) begin
          d_ip = tgt;
          d_jt = 1'b1;
        end
      end
      vmx_pkg::OP_CALL: begin
        if (!addr_ok(spv, 64'd8)) begin
          d_status = vmx_pkg::ST_BAD_ADDR;
        end else begin
          d_cls = vmx_pkg::CLS_MEM;
          d_mwr = 1'b1;
          d_mbase = spv;
          d_mlast = 3'd7;
          d_wdata = ip;
          d_sp_wr = 1'b1;
          d_sp_new = spv + 64'd8;
          d_ip = tgt;
          d_jt = 1'b1;
        end
      end
      vmx_pkg::OP_RET: begin
        if (spv < 64'd8) begin
          d_status = vmx_pkg::ST_UNDERFLOW;
        end else if (!addr_ok(sp_m8, 64'd8)) begin
          d_status = vmx_pkg::ST_BAD_ADDR;
        end else begin
          d_cls = vmx_pkg::CLS_MEM;
          d_mbase = sp_m8;
          d_mlast = 3'd7;
          d_sp_wr = 1'b1;
          d_sp_new = sp_m8;
          d_jt = 1'b1;
          d_ip_mem = 1'b1;
        end
      end
      vmx_pkg::OP_LD: begin
        if (!addr_ok(ea, nb64)) begin
          d_status = vmx_pkg::ST_BAD_ADDR;
        end else begin
          d_cls = vmx_pkg::CLS_MEM;
          d_mbase = ea;
          d_wr = 1'b1;
          d_src = vmx_pkg::SRC_MEM;
        end
      end
      vmx_pkg::OP_ST: begin
        if (!addr_ok(ea, nb64)) begin
          d_status = vmx_pkg::ST_BAD_ADDR;
        end else begin
          d_cls = vmx_pkg::CLS_MEM;
          d_mwr = 1'b1;
          d_mbase = ea;
          d_wdata = aval;
        end
      end
      vmx_pkg::OP_PUSH: begin
        if (!addr_ok(spv, nb64)) begin
          d_status = vmx_pkg::ST_BAD_ADDR;
        end else begin
          d_cls = vmx_pkg::CLS_MEM;
          d_mwr = 1'b1;
          d_mbase = spv;
          d_sp_wr = 1'b1;
          d_sp_new = spv + nb64;
        end
      end
      vmx_pkg::OP_POP: begin
        if (spv < nb64) begin
          d_status = vmx_pkg::ST_UNDERFLOW;
        end else if (!addr_ok(sp_mnb, nb64)) begin
          d_status = vmx_pkg::ST_BAD_ADDR;
        end else begin
          d_cls = vmx_pkg::CLS_MEM;
          d_mbase = sp_mnb;
          d_sp_wr = 1'b1;
          d_sp_new = sp_mnb;
          d_wr = 1'b1;
          d_src = vmx_pkg::SRC_MEM;
        end
      end
      vmx_pkg::OP_HALT: d_run = 1'b0;
      default: ;
    endcase
  end

  // restoring divide step: quotient bits shift into ma
  assign dtmp = {rem, ma[63]};
  assign dge  = (dtmp >= {1'b0, mb});

  assign mem_addr = res_mbase + AW'(mcnt);

  always_ff @(posedge clk) begin
    case (cmd)
      vmx_pkg::CMD_DECIDE: begin
        res_status <= d_status;
        res_src    <= d_src;
        res_wr     <= d_wr;
        res_jt     <= d_jt;
        res_run    <= d_run;
        res_sp_wr  <= d_sp_wr;
        res_ip_mem <= d_ip_mem;
        res_mwr    <= d_mwr;
        res_ip     <= d_ip;
        res_sp_new <= d_sp_new;
        res_wdata  <= d_wdata;
        res_flag   <= d_flag;
        res_mbase  <= d_mbase[AW-1:0];
        res_mlast  <= d_mlast;
        acc        <= d_wval;
        ma         <= aval;
        mb         <= opv;
        rem        <= 64'd0;
        cnt        <= 6'd0;
        mcnt       <= 3'd0;
      end
      vmx_pkg::CMD_MUL: begin
        acc <= acc + (mb[0] ? ma : 64'd0);
        ma  <= {ma[62:0], 1'b0};
        mb  <= {1'b0, mb[63:1]};
        cnt <= cnt + 6'd1;
      end
      vmx_pkg::CMD_DIV: begin
        rem <= dge ? 64'(dtmp - {1'b0, mb}) : dtmp[63:0];
        ma  <= {ma[62:0], dge};
        cnt <= cnt + 6'd1;
      end
      vmx_pkg::CMD_MEM: mcnt <= mcnt + 3'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd == vmx_pkg::CMD_MEM) begin
      if (res_mwr) mem[mem_addr] <= res_wdata[8*mcnt +: 8];
      else mem_q <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    rp_idx <= mcnt;
    if (cmd == vmx_pkg::CMD_DECIDE) rdata <= 64'd0;
    else if (rp_vld) rdata[8*rp_idx +: 8] <= mem_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp_vld <= 1'b0;
    end else begin
      rp_vld <= (cmd == vmx_pkg::CMD_MEM) && !res_mwr;
    end
  end

  always_comb begin
    case (res_src)
      vmx_pkg::SRC_QUO: wval_fin = ma;
      vmx_pkg::SRC_MEM: wval_fin = sx_q ? sext(rdata, dsz_q) : rdata;
      default:          wval_fin = acc;
    endcase
    ip_fin = res_ip_mem ? rdata : res_ip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ip        <= 64'd0;
      flag      <= vmx_pkg::FLAG_EQ;
      run       <= 1'b1;
      out_valid <= 1'b0;
    end else if (cmd == vmx_pkg::CMD_COMMIT) begin
      ip        <= ip_fin;
      flag      <= res_flag;
      run       <= res_run;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == vmx_pkg::CMD_COMMIT) begin
      status        <= res_status;
      reg_written   <= res_wr;
      written_value <= res_wr ? wval_fin : 64'd0;
      jump_taken    <= res_jt;
      next_ip       <= ip_fin;
      compare_flag  <= res_flag;
      is_running    <= res_run;
    end
  end

  always_comb begin
    stat.cls       = d_cls;
    stat.iter_done = (cnt == 6'd63);
    stat.mem_done  = (mcnt == res_mlast);
    stat.out_free  = !out_valid || !out_stall;
  end

endmodule
`default_nettype wire

[rtl/core/vm_instruction_execute_unit.sv]
// channel  | handshake            | payload
// in       | in_valid / in_stall  | mode .. jump_cond
// out      | out_valid / out_stall| status .. is_running
//
// one instruction at a time; after the transfer the control steps through reading src, dst and sp,
// capture, decide, a mul, div or memory phase where the op needs one (one byte of the memory
// port per cycle; 64 steps of one bit a cycle for mul and div), writing sp and the commit
// that raises out_valid; the next instruction is taken once the block is idle after the commit
// a new instruction is taken while the previous result waits in the output register.
// rst is synchronous: registers read as zero, ip and flag cleared, run bit set.
// out_stall holds the result and stops the next commit only.
`default_nettype none
module vm_instruction_execute_unit #(
  parameter int NUM_REGS  = 16,
  parameter int STACK_REG = 15,
  parameter int MEM_BYTES = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [3:0]         mode,
  input  wire logic [3:0]         dst_reg,
  input  wire logic [3:0]         src_reg,
  input  wire logic [2:0]         operand_kind,
  input  wire logic [63:0]        imm,
  input  wire logic signed [15:0] disp,
  input  wire logic [1:0]         data_size,
  input  wire logic               sign_extend,
  input  wire logic [2:0]         jump_cond,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              status,
  output logic                    reg_written,
  output logic [63:0]             written_value,
  output logic                    jump_taken,
  output logic [63:0]             next_ip,
  output logic signed [1:0]       compare_flag,
  output logic                    is_running
);

  vmx_pkg::cmd_e  cmd;
  vmx_pkg::stat_t stat;

  vmx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  vmx_dpath #(
    .NUM_REGS  (NUM_REGS),
    .STACK_REG (STACK_REG),
    .MEM_BYTES (MEM_BYTES)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .mode          (mode),
    .dst_reg       (dst_reg),
    .src_reg       (src_reg),
    .operand_kind  (operand_kind),
    .imm           (imm),
    .disp          (disp),
    .data_size     (data_size),
    .sign_extend   (sign_extend),
    .jump_cond     (jump_cond),
    .cmd           (cmd),
    .out_stall     (out_stall),
    .stat          (stat),
    .out_valid     (out_valid),
    .status        (status),
    .reg_written   (reg_written),
    .written_value (written_value),
    .jump_taken    (jump_taken),
    .next_ip       (next_ip),
    .compare_flag  (compare_flag),
    .is_running    (is_running)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block not busy after instruction transfer");

  a_flag_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (compare_flag != 2'sb10))
    else $error("illegal compare flag code");

  a_error_no_effect: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != vmx_pkg::ST_OK)) |-> (!reg_written && !jump_taken))
    else $error("failed instruction changed state");
`endif

endmodule
`default_nettype wire
